/* design/sftb_pkg.sv */
// ---------------------------------------------------------------------------
// sftb_pkg: shared types and constants of the splat compositor
// Fixed point formats, payload structs and the controller/datapath link.
// ---------------------------------------------------------------------------
`default_nettype none

package sftb_pkg;

	// fixed point format of colour and alpha
	localparam int FRAC_BITS = 16;
	localparam int ONE_W     = FRAC_BITS + 1;
	localparam int CH_W      = 16;
	localparam int PIX_W     = 16;

	localparam logic [ONE_W-1:0] ONE_Q  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [CH_W-1:0]  FULL_Q = (FRAC_BITS >= CH_W) ? {CH_W{1'b1}}
		: CH_W'((64'd1 << FRAC_BITS) - 64'd1);

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_CONTRIBUTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STOP_LEVEL       = 1'd1;

	typedef struct packed {
		logic                    has_splat;
		logic signed [PIX_W-1:0] offset_x;
		logic signed [PIX_W-1:0] offset_y;
		logic [PIX_W-1:0]        splat_radius;
		logic [CH_W-1:0]         splat_alpha;
		logic [CH_W-1:0]         splat_red;
		logic [CH_W-1:0]         splat_green;
		logic [CH_W-1:0]         splat_blue;
		logic                    pixel_done;
	} sftb_in_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
	} sftb_out_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic geo;
		logic cmp;
		logic col;
		logic acc;
	} sftb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pixel_done;
		logic out_blocked;
	} sftb_sts_t;

	// clamp a channel value to full scale
	function automatic logic [CH_W-1:0] clamp_full(input logic [CH_W-1:0] v);
		return (v > FULL_Q) ? FULL_Q : v;
	endfunction

	// saturating accumulate at full scale
	function automatic logic [CH_W-1:0] add_sat(input logic [CH_W-1:0] a,
		input logic [CH_W-1:0] b);
		logic [CH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, FULL_Q}) ? FULL_Q : s[CH_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/sftb_in_if.sv */
// ---------------------------------------------------------------------------
// sftb_in_if: splat contribution channel
// Valid/ready channel carrying one splat contribution per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sftb_in_if;
	logic               valid;
	logic               ready;
	sftb_pkg::sftb_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/sftb_out_if.sv */
// ---------------------------------------------------------------------------
// sftb_out_if: composited pixel channel
// Valid/ready channel carrying one RGBA pixel per transaction.
// ---------------------------------------------------------------------------
`default_nettype none

interface sftb_out_if;
	logic                valid;
	logic                ready;
	sftb_pkg::sftb_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/sftb_ctrl.sv */
// ---------------------------------------------------------------------------
// sftb_ctrl: compositor sequencer
// Steps one accepted contribution through geometry, compare, colour and
// accumulate, holding a closing item in accumulate while the previous pixel cannot leave.
// ---------------------------------------------------------------------------
`default_nettype none

module sftb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire sftb_pkg::sftb_sts_t sts,
	output sftb_pkg::sftb_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GEO  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_COL  = 3'd3;
	localparam logic [2:0] S_ACC  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       acc_stall;

	// a closing item waits while the previous pixel is still held
	assign acc_stall = sts.pixel_done && sts.out_blocked;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_nxt = S_GEO;
			S_GEO:  state_nxt = S_CMP;
			S_CMP:  state_nxt = S_COL;
			S_COL:  state_nxt = S_ACC;
			S_ACC:  if (!acc_stall) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// commands
	assign in_ready = (state_q == S_IDLE);
	assign cmd.load = in_ready && in_valid;
	assign cmd.geo  = (state_q == S_GEO);
	assign cmd.cmp  = (state_q == S_CMP);
	assign cmd.col  = (state_q == S_COL);
	assign cmd.acc  = (state_q == S_ACC) && !acc_stall;

endmodule

`default_nettype wire

/* design/sftb_dp.sv */
// ---------------------------------------------------------------------------
// sftb_dp: compositor datapath
// Holds the item, configuration, accumulators and output register, and does
// the radius test, the blend weight and the colour products.
// ---------------------------------------------------------------------------
`default_nettype none

module sftb_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire sftb_pkg::sftb_cmd_t                 cmd,
	output sftb_pkg::sftb_sts_t                      sts,
	input  wire sftb_pkg::sftb_in_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output sftb_pkg::sftb_out_t                      out_data,
	input  wire logic                                cfg_we,
	input  wire logic [sftb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [sftb_pkg::CFG_W-1:0]          cfg_data
);

	localparam int CH_W  = sftb_pkg::CH_W;
	localparam int SQ_W  = 2 * sftb_pkg::PIX_W;
	localparam int WP_W  = CH_W + sftb_pkg::ONE_W;
	localparam int CP_W  = 2 * CH_W;

	sftb_pkg::sftb_in_t item_q;
	logic [CH_W-1:0]    min_q;
	logic [CH_W-1:0]    stop_q;
	logic [CH_W-1:0]    sum_r_q, sum_g_q, sum_b_q, sum_a_q;
	logic [SQ_W-1:0]    sqx_q, sqy_q, rr_q;
	logic [WP_W-1:0]    wprod_q;
	logic               pre_ok_q;
	logic               hit_q;
	logic [CH_W-1:0]    w_q;
	logic [CH_W-1:0]    cr_q, cg_q, cb_q;
	logic               out_valid_q;
	sftb_pkg::sftb_out_t out_q;

	logic [CH_W-1:0]    abs_x, abs_y;
	logic [sftb_pkg::ONE_W-1:0] one_minus;
	logic [CH_W-1:0]    alpha_c;
	logic [SQ_W:0]      dist_sum;
	logic [CP_W-1:0]    prod_r, prod_g, prod_b;
	logic [CH_W-1:0]    nxt_r, nxt_g, nxt_b, nxt_a;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= 16'd257;
			stop_q <= 16'd64880;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sftb_pkg::CFG_MIN_CONTRIBUTION: min_q  <= cfg_data;
				sftb_pkg::CFG_STOP_LEVEL:       stop_q <= cfg_data;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) item_q <= in_data;
	end

	// geometry squares and blend weight product
	assign abs_x = item_q.offset_x[CH_W-1] ? CH_W'(-item_q.offset_x) : CH_W'(item_q.offset_x);
	assign abs_y = item_q.offset_y[CH_W-1] ? CH_W'(-item_q.offset_y) : CH_W'(item_q.offset_y);
	assign one_minus = sftb_pkg::ONE_Q - sftb_pkg::ONE_W'(sum_a_q);
	assign alpha_c   = sftb_pkg::clamp_full(item_q.splat_alpha);

	always_ff @(posedge clk) begin
		if (cmd.geo) begin
			sqx_q    <= SQ_W'(abs_x) * SQ_W'(abs_x);
			sqy_q    <= SQ_W'(abs_y) * SQ_W'(abs_y);
			rr_q     <= SQ_W'(item_q.splat_radius) * SQ_W'(item_q.splat_radius);
			wprod_q  <= WP_W'(alpha_c) * WP_W'(one_minus);
			pre_ok_q <= item_q.has_splat && (sum_a_q <= stop_q)
				&& (item_q.splat_alpha >= min_q);
		end
	end

	// radius test and weight
	assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			hit_q <= pre_ok_q && (dist_sum <= {1'b0, rr_q});
			w_q   <= CH_W'(wprod_q >> sftb_pkg::FRAC_BITS);
		end
	end

	// colour times weight
	assign prod_r = CP_W'(sftb_pkg::clamp_full(item_q.splat_red))   * CP_W'(w_q);
	assign prod_g = CP_W'(sftb_pkg::clamp_full(item_q.splat_green)) * CP_W'(w_q);
	assign prod_b = CP_W'(sftb_pkg::clamp_full(item_q.splat_blue))  * CP_W'(w_q);

	always_ff @(posedge clk) begin
		if (cmd.col) begin
			cr_q <= CH_W'(prod_r >> sftb_pkg::FRAC_BITS);
			cg_q <= CH_W'(prod_g >> sftb_pkg::FRAC_BITS);
			cb_q <= CH_W'(prod_b >> sftb_pkg::FRAC_BITS);
		end
	end

	// saturating accumulate
	assign nxt_r = hit_q ? sftb_pkg::add_sat(sum_r_q, cr_q) : sum_r_q;
	assign nxt_g = hit_q ? sftb_pkg::add_sat(sum_g_q, cg_q) : sum_g_q;
	assign nxt_b = hit_q ? sftb_pkg::add_sat(sum_b_q, cb_q) : sum_b_q;
	assign nxt_a = hit_q ? sftb_pkg::add_sat(sum_a_q, w_q)  : sum_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			sum_a_q <= '0;
		end else if (cmd.acc) begin
			if (item_q.pixel_done) begin
				sum_r_q <= '0;
				sum_g_q <= '0;
				sum_b_q <= '0;
				sum_a_q <= '0;
			end else begin
				sum_r_q <= nxt_r;
				sum_g_q <= nxt_g;
				sum_b_q <= nxt_b;
				sum_a_q <= nxt_a;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.acc && item_q.pixel_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc && item_q.pixel_done) begin
			out_q.out_red   <= nxt_r;
			out_q.out_green <= nxt_g;
			out_q.out_blue  <= nxt_b;
			out_q.out_alpha <= nxt_a;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign sts.pixel_done  = item_q.pixel_done;
	assign sts.out_blocked = out_valid_q && !out_ready;

endmodule

`default_nettype wire

/* design/splat_front_to_back_blend.sv */
// ---------------------------------------------------------------------------
// splat_front_to_back_blend: front-to-back splat compositor
// Blends depth-sorted splat contributions into one RGBA pixel.
//
//   channel  dir  payload                                  transaction
//   in_ch    in   sftb_in_t (splat contribution)           valid & ready
//   out_ch   out  sftb_out_t (composited RGBA)             valid & ready
//   cfg      in   cfg_index / cfg_data                     cfg_we
//
// An item steps through the accept cycle, then geometry, compare, colour
// and accumulate steps, each a registered step of the shared datapath.
// The accumulator loop (weight depends on the previous sum_alpha) is why items do not overlap.
// The finished pixel sits in an output register; the next items are accepted
// while it waits, and only a closing item stalls in accumulate until it leaves.
// Reset clears the sums and loads the register defaults; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module splat_front_to_back_blend (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	sftb_in_if.sink                             in_ch,
	sftb_out_if.source                          out_ch,
	input  wire logic                           cfg_we,
	input  wire logic [sftb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sftb_pkg::CFG_W-1:0]     cfg_data
);

	sftb_pkg::sftb_cmd_t cmd;
	sftb_pkg::sftb_sts_t sts;

	// sequencer
	sftb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	sftb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_ch.data),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_ch.data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// one step at a time
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.geo, cmd.cmp, cmd.col, cmd.acc}))
		else $error("more than one datapath step at once");

	// an accepted item keeps the input closed while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while an item is in flight");

	// a closing item always produces a pixel
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && sts.pixel_done |=> out_ch.valid)
		else $error("closing item did not produce a pixel");

	// accumulate never runs over an unread pixel for a closing item
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc && sts.pixel_done |-> !sts.out_blocked)
		else $error("pixel overwritten before transaction");

endmodule

`default_nettype wire

/* bench/sftb_blend_checker.sv */
// ---------------------------------------------------------------------------
// sftb_blend_checker: scoreboard of the splat compositor
// Watches the splat and pixel channels and the register port. It blends
// each accepted splat into its own copy of the sums, queues the pixel that
// a closing transaction produces, and compares every returned pixel field
// by field with the oldest one queued.
// ---------------------------------------------------------------------------
`default_nettype none

module sftb_blend_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire sftb_pkg::sftb_in_t             in_data,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire sftb_pkg::sftb_out_t            out_data,
	input  wire logic                           cfg_we,
	input  wire logic [sftb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sftb_pkg::CFG_W-1:0]     cfg_data,
	output int                                  fail_count,
	output int                                  pending
);

	// blending state and register copies
	logic [sftb_pkg::CH_W-1:0]  acc_red;
	logic [sftb_pkg::CH_W-1:0]  acc_green;
	logic [sftb_pkg::CH_W-1:0]  acc_blue;
	logic [sftb_pkg::CH_W-1:0]  acc_alpha;
	logic [sftb_pkg::CFG_W-1:0] min_contrib;
	logic [sftb_pkg::CFG_W-1:0] stop_lvl;

	sftb_pkg::sftb_out_t pixel_queue[$];
	sftb_pkg::sftb_out_t want_px;
	sftb_pkg::sftb_out_t made_px;
	int                  mism = 0;
	int                  pixels_seen = 0;

	// inputs above full scale are held at full scale
	function automatic logic [sftb_pkg::CH_W-1:0] to_full(
		input logic [sftb_pkg::CH_W-1:0] v);
		return (v > sftb_pkg::FULL_Q) ? sftb_pkg::FULL_Q : v;
	endfunction

	// add with saturation at full scale
	function automatic logic [sftb_pkg::CH_W-1:0] accumulate(
		input logic [sftb_pkg::CH_W-1:0] acc, input longint unsigned add);
		longint unsigned s;
		s = acc + add;
		return (s > sftb_pkg::FULL_Q) ? sftb_pkg::FULL_Q : sftb_pkg::CH_W'(s);
	endfunction

	// blend one contribution; returns 1 with the pixel when it closes one
	function automatic bit blend_contribution(input sftb_pkg::sftb_in_t it,
		output sftb_pkg::sftb_out_t px);
		longint          dx;
		longint          dy;
		longint          dist_sq;
		longint          reach_sq;
		longint unsigned a;
		longint unsigned rem;
		longint unsigned wgt;
		longint unsigned add_r;
		longint unsigned add_g;
		longint unsigned add_b;
		px = '0;
		if (it.has_splat && acc_alpha <= stop_lvl) begin
			dx = longint'($signed(it.offset_x));
			dy = longint'($signed(it.offset_y));
			dist_sq = dx * dx + dy * dy;
			reach_sq = longint'(it.splat_radius) * longint'(it.splat_radius);
			// on the edge counts, threshold compared before clamping
			if (dist_sq <= reach_sq && it.splat_alpha >= min_contrib) begin
				a = to_full(it.splat_alpha);
				rem = sftb_pkg::ONE_Q - acc_alpha;
				wgt = (a * rem) >> sftb_pkg::FRAC_BITS;
				add_r = (to_full(it.splat_red) * wgt) >> sftb_pkg::FRAC_BITS;
				add_g = (to_full(it.splat_green) * wgt) >> sftb_pkg::FRAC_BITS;
				add_b = (to_full(it.splat_blue) * wgt) >> sftb_pkg::FRAC_BITS;
				acc_red = accumulate(acc_red, add_r);
				acc_green = accumulate(acc_green, add_g);
				acc_blue = accumulate(acc_blue, add_b);
				acc_alpha = accumulate(acc_alpha, wgt);
			end
		end
		if (!it.pixel_done)
			return 0;
		px.out_red = acc_red;
		px.out_green = acc_green;
		px.out_blue = acc_blue;
		px.out_alpha = acc_alpha;
		acc_red = '0;
		acc_green = '0;
		acc_blue = '0;
		acc_alpha = '0;
		return 1;
	endfunction

	// compare returned pixels, then track register writes and new splats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_red = '0;
			acc_green = '0;
			acc_blue = '0;
			acc_alpha = '0;
			min_contrib = 16'd257;
			stop_lvl = 16'd64880;
			pixel_queue.delete();
			pending <= 0;
			fail_count <= mism;
		end else begin
			if (out_valid && out_ready) begin
				pixels_seen++;
				if (pixel_queue.size() == 0) begin
					mism++;
					if (mism <= 10)
						$display("pixel %0d: unexpected transaction r=%h g=%h b=%h a=%h",
							pixels_seen, out_data.out_red, out_data.out_green,
							out_data.out_blue, out_data.out_alpha);
				end else begin
					want_px = pixel_queue.pop_front();
					if (out_data.out_red !== want_px.out_red
						|| out_data.out_green !== want_px.out_green
						|| out_data.out_blue !== want_px.out_blue
						|| out_data.out_alpha !== want_px.out_alpha) begin
						mism++;
						if (mism <= 10)
							$display("pixel %0d: exp r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
								pixels_seen, want_px.out_red, want_px.out_green,
								want_px.out_blue, want_px.out_alpha, out_data.out_red,
								out_data.out_green, out_data.out_blue, out_data.out_alpha);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					sftb_pkg::CFG_MIN_CONTRIBUTION: min_contrib = cfg_data;
					sftb_pkg::CFG_STOP_LEVEL:       stop_lvl = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (blend_contribution(in_data, made_px))
					pixel_queue = {pixel_queue, made_px};
			end
			pending <= pixel_queue.size();
			fail_count <= mism;
		end
	end

endmodule

`default_nettype wire

/* bench/splat_front_to_back_blend_tb.sv */
// ---------------------------------------------------------------------------
// splat_front_to_back_blend_tb: testbench of the splat compositor
// Sends a directed set of edge cases, then random depth-sorted pixels under
// several register settings, with random gaps and stalls on both channels,
// a long output hold-off and full drains. A scoreboard checks every pixel.
// ---------------------------------------------------------------------------
`default_nettype none

module splat_front_to_back_blend_tb;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [sftb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sftb_pkg::CFG_W-1:0]     cfg_data;
	int                             fail_count;
	int                             pending;

	int items_sent = 0;
	int pixels_closed = 0;
	int settings_used = 0;
	int hold_cycles = 0;
	bit send_burst = 0;
	bit recv_burst = 0;

	sftb_in_if  in_if();
	sftb_out_if out_if();

	splat_front_to_back_blend u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sftb_blend_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_if.valid),
		.in_ready   (in_if.ready),
		.in_data    (in_if.data),
		.out_valid  (out_if.valid),
		.out_ready  (out_if.ready),
		.out_data   (out_if.data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#3200000;
		$display("end of test: mismatches");
		$finish;
	end

	// pixel receiver with random stalls and an optional long hold-off
	initial begin
		int stall;
		out_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				recv_burst = !recv_burst;
			stall = recv_burst ? 0 : $urandom_range(0, 11);
			if (hold_cycles > 0) begin
				stall = hold_cycles;
				hold_cycles = 0;
			end
			if (stall > 0) begin
				out_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_if.ready <= 1'b1;
			do @(posedge clk); while (!out_if.valid);
		end
	end

	// one splat with given geometry, opacity and colour
	function automatic sftb_pkg::sftb_in_t splat_at(input int dx, input int dy, input int r,
		input int a, input int cr, input int cg, input int cb, input bit done);
		sftb_pkg::sftb_in_t it;
		it.has_splat = 1'b1;
		it.offset_x = 16'(dx);
		it.offset_y = 16'(dy);
		it.splat_radius = 16'(r);
		it.splat_alpha = 16'(a);
		it.splat_red = 16'(cr);
		it.splat_green = 16'(cg);
		it.splat_blue = 16'(cb);
		it.pixel_done = done;
		return it;
	endfunction

	// random splat, mostly near or inside its radius
	function automatic sftb_pkg::sftb_in_t make_splat();
		sftb_pkg::sftb_in_t it;
		int                 r;
		int                 lim;
		int                 mag;
		it = '0;
		it.has_splat = 1'b1;
		if ($urandom_range(0, 3) == 0) begin
			r = $urandom_range(0, 65535);
			it.offset_x = 16'($urandom);
			it.offset_y = 16'($urandom);
		end else begin
			r = $urandom_range(0, 1600);
			lim = (r > 32767) ? 32767 : r;
			mag = $urandom_range(0, lim);
			it.offset_x = 16'($urandom_range(0, 1) ? -mag : mag);
			mag = $urandom_range(0, lim);
			it.offset_y = 16'($urandom_range(0, 1) ? -mag : mag);
		end
		it.splat_radius = 16'(r);
		case ($urandom_range(0, 7))
			0:       it.splat_alpha = 16'hFFFF;
			1:       it.splat_alpha = 16'($urandom_range(0, 600));
			2:       it.splat_alpha = 16'($urandom_range(60000, 65535));
			default: it.splat_alpha = 16'($urandom_range(0, 65535));
		endcase
		it.splat_red = 16'($urandom_range(0, 65535));
		it.splat_green = 16'($urandom_range(0, 65535));
		it.splat_blue = 16'($urandom_range(0, 65535));
		it.pixel_done = 1'b0;
		return it;
	endfunction

	// item with no splat and random leftover fields
	function automatic sftb_pkg::sftb_in_t make_empty(input bit done);
		sftb_pkg::sftb_in_t it;
		it = make_splat();
		it.has_splat = 1'b0;
		it.pixel_done = done;
		return it;
	endfunction

	// offer one transaction after a random gap, return once accepted
	task automatic send_item(input sftb_pkg::sftb_in_t it);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= it;
		do @(posedge clk); while (!in_if.ready);
		items_sent++;
		if (it.pixel_done)
			pixels_closed++;
	endtask

	// stop offering and wait for every queued pixel
	task automatic drain_results();
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic set_config(input logic [sftb_pkg::CFG_W-1:0] min_val,
		input logic [sftb_pkg::CFG_W-1:0] stop_val);
		drain_results();
		repeat (12) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sftb_pkg::CFG_MIN_CONTRIBUTION;
		cfg_data <= min_val;
		@(posedge clk);
		cfg_index <= sftb_pkg::CFG_STOP_LEVEL;
		cfg_data <= stop_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	// edge cases under the reset register values
	task automatic run_directed();
		// empty pixel
		send_item(make_empty(1'b1));
		// exactly on the radius edge, then one step outside
		send_item(splat_at(48, 64, 80, 32768, 65535, 0, 12345, 1'b1));
		send_item(splat_at(48, 64, 79, 40000, 1000, 2000, 3000, 1'b1));
		// extreme offsets inside a full radius, then saturated pixel skips
		send_item(splat_at(-32768, -32768, 65535, 65535, 65535, 65535, 65535, 1'b0));
		send_item(splat_at(0, 0, 0, 65535, 100, 200, 300, 1'b0));
		send_item(make_empty(1'b1));
		// zero radius with a far offset, and a wide opposite-sign offset
		send_item(splat_at(32767, 0, 0, 50000, 1, 2, 3, 1'b1));
		send_item(splat_at(32767, -32768, 65535, 30000, 40000, 50000, 60000, 1'b1));
		// opacity just below and exactly at the threshold
		send_item(splat_at(0, 0, 0, 256, 65535, 65535, 65535, 1'b0));
		send_item(splat_at(0, 0, 0, 257, 65535, 65535, 65535, 1'b1));
		// alpha reaches the stop level exactly, one more counts, then skipped
		send_item(splat_at(0, 0, 16, 64880, 1000, 2000, 3000, 1'b0));
		send_item(splat_at(0, 0, 16, 65535, 65535, 65535, 65535, 1'b0));
		send_item(splat_at(0, 0, 16, 65535, 65535, 65535, 65535, 1'b0));
		send_item(make_empty(1'b1));
		// black and white splats
		send_item(splat_at(-5, 7, 20, 20000, 0, 0, 0, 1'b1));
		send_item(splat_at(5, -7, 20, 65535, 65535, 65535, 65535, 1'b1));
		// ignored empty items between splats of one pixel
		send_item(make_empty(1'b0));
		send_item(splat_at(1, 1, 2, 30000, 50000, 10000, 40000, 1'b0));
		send_item(make_empty(1'b0));
		send_item(splat_at(-1, -1, 2, 30000, 20000, 60000, 5000, 1'b0));
		send_item(make_empty(1'b1));
	endtask

	// random pixels until the item budget of the phase is spent
	task automatic run_pixels(input int budget);
		int                 used;
		int                 nsplat;
		bit                 close_on_splat;
		sftb_pkg::sftb_in_t it;
		used = 0;
		while (used < budget) begin
			if ($urandom_range(0, 15) == 0)
				send_burst = !send_burst;
			if ($urandom_range(0, 39) == 0)
				drain_results();
			nsplat = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
				: $urandom_range(0, 3);
			close_on_splat = (nsplat > 0) && $urandom_range(0, 1);
			for (int i = 0; i < nsplat; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_item(make_empty(1'b0));
				it = make_splat();
				it.pixel_done = close_on_splat && (i == nsplat - 1);
				send_item(it);
				used++;
			end
			if (!close_on_splat) begin
				send_item(make_empty(1'b1));
				used++;
			end
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= sftb_pkg::CFG_MIN_CONTRIBUTION;
		cfg_data <= '0;
		in_if.valid <= 1'b0;
		in_if.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_pixels(150);

		// lowest threshold, never stop
		set_config(16'd0, 16'hFFFF);
		send_item(splat_at(0, 0, 0, 0, 65535, 65535, 65535, 1'b1));
		run_pixels(300);

		// highest threshold, stop after the first counted splat
		set_config(16'hFFFF, 16'd0);
		run_pixels(300);

		// random setting with the receiver held off for a long stretch
		set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		hold_cycles = 400;
		send_burst = 1'b1;
		run_pixels(300);

		set_config(16'd1, 16'd32768);
		run_pixels(300);

		// back to the reset values
		set_config(16'd257, 16'd64880);
		run_pixels(250);

		drain_results();
		repeat (20) @(posedge clk);
		$display("covered %0d splat transactions over %0d pixels under %0d register settings",
			items_sent, pixels_closed, settings_used + 1);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
design/sftb_pkg.sv
design/sftb_in_if.sv
design/sftb_out_if.sv
design/sftb_ctrl.sv
design/sftb_dp.sv
design/splat_front_to_back_blend.sv
bench/sftb_blend_checker.sv
bench/splat_front_to_back_blend_tb.sv
